>>> hw/rtl/mbrp_pkg.sv
// Shared types and constants for the MBR partition table parser.
// Holds the channel item structs and the controller/datapath command and status.
// No dependencies.
package mbrp_pkg;

  // Sector layout
  localparam int unsigned MBRP_ENTRY_COUNT = 4;
  localparam int unsigned MBRP_ENTRY_BYTES = 16;
  localparam logic [8:0]  MBRP_TABLE_BASE  = 9'd446;
  localparam logic [8:0]  MBRP_SIG_POS     = 9'd510;
  localparam logic [8:0]  MBRP_LAST_POS    = 9'd511;
  localparam logic [7:0]  MBRP_SIG_LOW     = 8'h55;
  localparam logic [7:0]  MBRP_SIG_HIGH    = 8'hAA;

  // Entry field offsets within a 16-byte table entry
  localparam logic [3:0]  MBRP_OFF_BOOT    = 4'd0;
  localparam logic [3:0]  MBRP_OFF_TYPE    = 4'd4;
  localparam logic [3:0]  MBRP_OFF_START   = 4'd8;
  localparam logic [3:0]  MBRP_OFF_COUNT   = 4'd12;

  // One input item
  typedef struct packed {
    logic [7:0] sector_byte;
    logic       sector_restart;
  } mbrp_in_t;

  // One result item
  typedef struct packed {
    logic        signature_valid;
    logic [1:0]  entry_index;
    logic        entry_present;
    logic [7:0]  boot_flag;
    logic [7:0]  partition_type;
    logic [31:0] first_sector;
    logic [31:0] sector_total;
    logic        last_result;
  } mbrp_out_t;

  // Stored table entry
  typedef struct packed {
    logic [7:0]  boot;
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] count;
  } mbrp_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       take_byte;
    logic       load_bad;
    logic       load_entry;
    logic [1:0] entry_sel;
    logic       last;
  } mbrp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_last_byte;
    logic sig_ok;
    logic out_busy;
  } mbrp_status_t;

endpackage

>>> hw/rtl/mbrp_datapath.sv
// Datapath of the MBR parser: byte position, table entry store, signature
// byte and the result output register. Depends on mbrp_pkg.
module mbrp_datapath #(
  parameter int unsigned ENTRY_COUNT = mbrp_pkg::MBRP_ENTRY_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mbrp_pkg::mbrp_in_t    byte_item,
  input  mbrp_pkg::mbrp_cmd_t   cmd,
  output mbrp_pkg::mbrp_status_t status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output mbrp_pkg::mbrp_out_t   result_item
);
  import mbrp_pkg::*;

  localparam int unsigned IDX_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned TABLE_END = 446 + MBRP_ENTRY_BYTES * ENTRY_COUNT;

  logic [8:0]  byte_position;
  logic [7:0]  signature_low_byte;
  mbrp_entry_t entry_store [ENTRY_COUNT];

  logic [8:0]       pos_cur;
  logic [8:0]       rel;
  logic [8:0]       rel_entry;
  logic [8:0]       rel_off;
  logic [3:0]       off;
  logic [IDX_W-1:0] wr_idx;
  logic             in_table;
  logic [1:0]       lane;
  mbrp_entry_t      rd_entry;

  // Offset of the current byte, restart forces zero
  always_comb begin
    pos_cur   = byte_item.sector_restart ? 9'd0 : byte_position;
    rel       = pos_cur - MBRP_TABLE_BASE;
    rel_entry = rel / 9'(MBRP_ENTRY_BYTES);
    rel_off   = rel % 9'(MBRP_ENTRY_BYTES);
    off       = rel_off[3:0];
    wr_idx    = rel_entry[IDX_W-1:0];
    lane      = off[1:0];
    in_table  = (pos_cur >= MBRP_TABLE_BASE) && ({1'b0, pos_cur} < 10'(TABLE_END));
  end

  assign status.at_last_byte = (pos_cur == MBRP_LAST_POS);
  assign status.sig_ok       = (signature_low_byte == MBRP_SIG_LOW) &&
                               (byte_item.sector_byte == MBRP_SIG_HIGH);
  assign status.out_busy     = result_valid && result_stall;

  // Position and signature byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      signature_low_byte <= '0;
    end else if (cmd.take_byte) begin
      byte_position <= pos_cur + 9'd1;
      if (pos_cur == MBRP_SIG_POS) begin
        signature_low_byte <= byte_item.sector_byte;
      end
    end
  end

  // Table capture; CHS bytes are skipped
  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_table) begin
      priority if (off == MBRP_OFF_BOOT) begin
        entry_store[wr_idx].boot <= byte_item.sector_byte;
      end else if (off == MBRP_OFF_TYPE) begin
        entry_store[wr_idx].ptype <= byte_item.sector_byte;
      end else if (off >= MBRP_OFF_COUNT) begin
        entry_store[wr_idx].count[lane*8 +: 8] <= byte_item.sector_byte;
      end else if (off >= MBRP_OFF_START) begin
        entry_store[wr_idx].start[lane*8 +: 8] <= byte_item.sector_byte;
      end
    end
  end

  assign rd_entry = entry_store[cmd.entry_sel[IDX_W-1:0]];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_bad || cmd.load_entry) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bad) begin
      result_item <= '{last_result: 1'b1, default: '0};
    end else if (cmd.load_entry) begin
      result_item.signature_valid <= 1'b1;
      result_item.entry_index     <= cmd.entry_sel;
      result_item.entry_present   <= (rd_entry.ptype != 8'd0) && (rd_entry.count != 32'd0);
      result_item.boot_flag       <= rd_entry.boot;
      result_item.partition_type  <= rd_entry.ptype;
      result_item.first_sector    <= rd_entry.start;
      result_item.sector_total    <= rd_entry.count;
      result_item.last_result     <= cmd.last;
    end
  end

endmodule

>>> hw/rtl/mbrp_ctrl.sv
// Controller of the MBR parser: byte acceptance and sequencing of entry results.
// Depends on mbrp_pkg.
module mbrp_ctrl #(
  parameter int unsigned ENTRY_COUNT = mbrp_pkg::MBRP_ENTRY_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  mbrp_pkg::mbrp_status_t status,
  output mbrp_pkg::mbrp_cmd_t    cmd
);
  import mbrp_pkg::*;

  localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic        ST_IDLE = 1'b0;
  localparam logic        ST_EMIT = 1'b1;

  logic             state;
  logic             state_next;
  logic [IDX_W-1:0] entry_cnt;
  logic [IDX_W-1:0] entry_cnt_next;
  logic             accept;
  logic             cnt_last;

  assign cnt_last = (entry_cnt == IDX_W'(ENTRY_COUNT - 1));
  assign accept   = byte_valid && !byte_stall;

  // Next state and commands
  always_comb begin
    state_next     = state;
    entry_cnt_next = entry_cnt;
    cmd            = '0;
    byte_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // only the final byte needs the output register free
        byte_stall    = status.at_last_byte && status.out_busy;
        cmd.take_byte = accept;
        if (accept && status.at_last_byte) begin
          if (!status.sig_ok) begin
            cmd.load_bad = 1'b1;
          end else begin
            cmd.load_entry = 1'b1;
            cmd.entry_sel  = 2'd0;
            cmd.last       = (ENTRY_COUNT == 1);
            if (ENTRY_COUNT > 1) begin
              state_next     = ST_EMIT;
              entry_cnt_next = IDX_W'(1);
            end
          end
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.load_entry = 1'b1;
          cmd.entry_sel  = 2'(entry_cnt);
          cmd.last       = cnt_last;
          entry_cnt_next = entry_cnt + IDX_W'(1);
          if (cnt_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      entry_cnt <= '0;
    end else begin
      state     <= state_next;
      entry_cnt <= entry_cnt_next;
    end
  end

endmodule

>>> hw/rtl/mbr_partition_table_parser.sv
// MBR partition table parser, top level.
// Bytes of a disk's first sector enter on the byte channel, one item per byte
// in sector order; sector_restart marks a byte as offset zero, and after
// offset 511 the position wraps to zero on its own.
// Table entries at offsets 446..509 and the signature at 510/511 are captured.
// On byte 511 the result channel gives ENTRY_COUNT entry items (index 0 first,
// last_result on the final one) if the signature is 0x55 0xAA, else one item
// with signature_valid clear.
// Throughput: one byte per cycle outside the stalls below. The first result is
// registered and appears in the cycle after byte 511 is taken; with a good
// signature the further entries follow one per cycle unless the receiver
// stalls, and the byte channel stalls until the controller has stepped through them.
// Byte 511 is also stalled while a previous result still waits in the output
// register; other bytes outside an entry run are taken even then. A stalled
// result item holds.
// Reset clears the byte position, the signature byte and the output valid;
// the entry store is not cleared, each entry is rewritten by every sector.
// Depends on mbrp_pkg, mbrp_ctrl and mbrp_datapath.
module mbr_partition_table_parser #(
  parameter int unsigned ENTRY_COUNT = mbrp_pkg::MBRP_ENTRY_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  mbrp_pkg::mbrp_in_t  byte_item,
  output logic                result_valid,
  input  logic                result_stall,
  output mbrp_pkg::mbrp_out_t result_item
);
  import mbrp_pkg::*;

  mbrp_cmd_t    cmd;
  mbrp_status_t status;

  mbrp_ctrl #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mbrp_datapath #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .byte_item   (byte_item),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item)
  );

endmodule

>>> hw/rtl/mbrp_checker.sv
// Port-level checks for the MBR partition table parser, with its bind.
// Depends on mbrp_pkg and mbr_partition_table_parser.
module mbrp_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_stall,
  input mbrp_pkg::mbrp_in_t  byte_item,
  input logic                result_valid,
  input logic                result_stall,
  input mbrp_pkg::mbrp_out_t result_item
);

  // Stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("result item changed while stalled");

  // A bad signature is a single, final item
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.signature_valid |->
      result_item.last_result && result_item.entry_index == 2'd0 &&
      !result_item.entry_present)
    else $error("bad-signature item malformed");

  // Entry items follow back to back with rising index
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result_item.last_result |=>
      result_valid &&
      result_item.entry_index == $past(result_item.entry_index) + 2'd1)
    else $error("entry sequence broken");

  // Presence needs a type and a count
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.entry_present |->
      result_item.signature_valid && result_item.partition_type != 8'd0 &&
      result_item.sector_total != 32'd0)
    else $error("entry marked present without type or count");

  // Bytes are held back only while a result is pending; a held byte stays put
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |-> result_valid ##1 (byte_valid && $stable(byte_item)))
    else $error("byte stall without pending result, or held byte changed");

endmodule

bind mbr_partition_table_parser mbrp_checker u_mbrp_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .byte_item   (byte_item),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_item (result_item)
);

>>> test/mbr_partition_table_parser_test.sv
// Self-checking testbench for mbr_partition_table_parser: streams whole, wrapped and broken
// sectors byte by byte, predicts the partition entry items and checks every result item.
// Depends on mbrp_pkg and the mbr_partition_table_parser RTL.
module mbr_partition_table_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrp_pkg::*;

  localparam int unsigned NUM_ENTRIES    = MBRP_ENTRY_COUNT;
  localparam int unsigned SECTOR_BYTES   = 512;
  localparam int unsigned HANG_LIMIT     = 2000;
  localparam int unsigned RANDOM_SECTORS = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  mbrp_in_t  byte_item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  mbrp_out_t result_item;

  mbr_partition_table_parser #(.ENTRY_COUNT(NUM_ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item)
  );

  always #2 clk = ~clk;

  // Shadow of the parser state
  logic [8:0]  next_offset = '0;
  logic [7:0]  sig_low_seen = '0;
  mbrp_entry_t table_copy [4];
  mbrp_out_t   awaited_results [$];

  int error_count  = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit idle_on      = 1'b1;

  // Sector being sent and the entries written into it
  logic [7:0]  sector_img [SECTOR_BYTES];
  mbrp_entry_t plan [4];

  // Track one accepted byte; queue the entry items that byte 511 releases
  function automatic void decode_sector_byte(input mbrp_in_t it);
    logic [8:0]  pos;
    logic [8:0]  rel;
    int unsigned slot;
    int          k;
    logic [3:0]  off;
    mbrp_out_t   r;
    pos = it.sector_restart ? 9'd0 : next_offset;
    next_offset = pos + 9'd1;
    if (pos == MBRP_SIG_POS) begin
      sig_low_seen = it.sector_byte;
    end else if (pos == MBRP_LAST_POS) begin
      if (sig_low_seen != MBRP_SIG_LOW || it.sector_byte != MBRP_SIG_HIGH) begin
        r = '0;
        r.last_result = 1'b1;
        awaited_results.push_back(r);
      end else begin
        for (k = 0; k < NUM_ENTRIES; k++) begin
          r.signature_valid = 1'b1;
          r.entry_index     = 2'(k);
          r.entry_present   = (table_copy[k].ptype != 8'd0) && (table_copy[k].count != 32'd0);
          r.boot_flag       = table_copy[k].boot;
          r.partition_type  = table_copy[k].ptype;
          r.first_sector    = table_copy[k].start;
          r.sector_total    = table_copy[k].count;
          r.last_result     = (k == NUM_ENTRIES - 1);
          awaited_results.push_back(r);
        end
      end
    end else if (pos >= MBRP_TABLE_BASE &&
                 pos < MBRP_TABLE_BASE + MBRP_ENTRY_BYTES * NUM_ENTRIES) begin
      rel  = pos - MBRP_TABLE_BASE;
      slot = rel / MBRP_ENTRY_BYTES;
      off  = rel[3:0];
      // CHS bytes fall through untouched
      if (off == MBRP_OFF_BOOT)
        table_copy[slot].boot = it.sector_byte;
      else if (off == MBRP_OFF_TYPE)
        table_copy[slot].ptype = it.sector_byte;
      else if (off >= MBRP_OFF_START && off < MBRP_OFF_COUNT)
        table_copy[slot].start[8*off[1:0] +: 8] = it.sector_byte;
      else if (off >= MBRP_OFF_COUNT)
        table_copy[slot].count[8*off[1:0] +: 8] = it.sector_byte;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : result_check
    mbrp_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result item, expected none, actual 0x%0h",
                 $time, result_item);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("signature_valid", 32'(want.signature_valid),
                    32'(result_item.signature_valid));
        check_field("entry_index", 32'(want.entry_index), 32'(result_item.entry_index));
        check_field("entry_present", 32'(want.entry_present),
                    32'(result_item.entry_present));
        check_field("boot_flag", 32'(want.boot_flag), 32'(result_item.boot_flag));
        check_field("partition_type", 32'(want.partition_type),
                    32'(result_item.partition_type));
        check_field("first_sector", want.first_sector, result_item.first_sector);
        check_field("sector_total", want.sector_total, result_item.sector_total);
        check_field("last_result", 32'(want.last_result), 32'(result_item.last_result));
      end
    end
  end

  // Receiver back-pressure in random bursts while idling is enabled
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Send one byte item, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] value, input logic restart);
    mbrp_in_t it;
    it.sector_byte    = value;
    it.sector_restart = restart;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    byte_item  <= it;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    decode_sector_byte(it);
    @(negedge clk);
  endtask

  // Fill the sector image with noise, then lay the planned entries and signature over it
  function automatic void build_sector(input logic [7:0] sig_lo, input logic [7:0] sig_hi);
    int unsigned base;
    int          p;
    int          j;
    for (p = 0; p < SECTOR_BYTES; p++) sector_img[p] = 8'($urandom);
    for (p = 0; p < 4; p++) begin
      base = MBRP_TABLE_BASE + MBRP_ENTRY_BYTES * p;
      sector_img[base + MBRP_OFF_BOOT] = plan[p].boot;
      sector_img[base + MBRP_OFF_TYPE] = plan[p].ptype;
      for (j = 0; j < 4; j++) begin
        sector_img[base + MBRP_OFF_START + j] = plan[p].start[8*j +: 8];
        sector_img[base + MBRP_OFF_COUNT + j] = plan[p].count[8*j +: 8];
      end
    end
    sector_img[MBRP_SIG_POS]  = sig_lo;
    sector_img[MBRP_LAST_POS] = sig_hi;
  endfunction

  task automatic send_sector(input int unsigned nbytes, input bit restart_first);
    int unsigned p;
    for (p = 0; p < nbytes; p++) send_byte(sector_img[p], restart_first && p == 0);
  endtask

  function automatic mbrp_entry_t random_entry();
    mbrp_entry_t e;
    e.boot  = ($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom);
    e.ptype = 8'($urandom);
    e.start = $urandom;
    e.count = $urandom;
    case ($urandom_range(0, 7))
      0:       e.ptype = '0;
      1:       e.count = '0;
      2:       e.count = '1;
      3:       e.start = '0;
      4:       e.count = $urandom_range(1, 255);
      default: ;
    endcase
    return e;
  endfunction

  // Extremes of every entry field, present and absent entries
  task automatic test_extreme_entries();
    plan[0] = '1;
    plan[1] = '0;
    plan[2] = '{boot: 8'h80, ptype: 8'hFF, start: 32'hFFFF_FFFF, count: 32'd0};
    plan[3] = '{boot: 8'h00, ptype: 8'h00, start: 32'd0, count: 32'hFFFF_FFFF};
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH);
    send_sector(SECTOR_BYTES, 1'b1);
    plan[0] = '{boot: 8'h00, ptype: 8'h01, start: 32'd0, count: 32'd1};
    plan[1] = '{boot: 8'h7F, ptype: 8'h80, start: 32'h8000_0000, count: 32'h0000_0001};
    plan[2] = random_entry();
    plan[3] = random_entry();
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH);
    send_sector(SECTOR_BYTES, 1'b1);
  endtask

  // Wrong signature in each byte, and swapped
  task automatic test_bad_signatures();
    int k;
    for (k = 0; k < 4; k++) plan[k] = random_entry();
    build_sector(MBRP_SIG_HIGH, MBRP_SIG_LOW);
    send_sector(SECTOR_BYTES, 1'b1);
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH ^ 8'h01);
    send_sector(SECTOR_BYTES, 1'b1);
    build_sector(MBRP_SIG_LOW ^ 8'h80, MBRP_SIG_HIGH);
    send_sector(SECTOR_BYTES, 1'b1);
  endtask

  // Second sector follows the first with no restart flag
  task automatic test_sector_wrap();
    int k;
    for (k = 0; k < 4; k++) plan[k] = random_entry();
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH);
    send_sector(SECTOR_BYTES, 1'b1);
    for (k = 0; k < 4; k++) plan[k] = random_entry();
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH);
    send_sector(SECTOR_BYTES, 1'b0);
  endtask

  // Restart cuts a sector short: just before its last byte and inside the table
  task automatic test_restart_mid_sector();
    int k;
    for (k = 0; k < 4; k++) plan[k] = random_entry();
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH);
    send_sector(SECTOR_BYTES - 1, 1'b1);
    for (k = 0; k < 4; k++) plan[k] = random_entry();
    build_sector(MBRP_SIG_LOW, MBRP_SIG_HIGH);
    send_sector($urandom_range(MBRP_TABLE_BASE + 1, MBRP_SIG_POS - 1), 1'b1);
    send_sector(SECTOR_BYTES, 1'b1);
  endtask

  // Mostly well-formed sectors with random content; some noise and cut-short sectors
  task automatic test_random_sectors();
    int         s;
    int         k;
    bit         aligned;
    logic [7:0] lo;
    logic [7:0] hi;
    aligned = 1'b1;
    for (s = 0; s < RANDOM_SECTORS; s++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (k = 0; k < 4; k++) plan[k] = random_entry();
      case ($urandom_range(0, 7))
        0: begin lo = MBRP_SIG_HIGH; hi = MBRP_SIG_LOW; end
        1: begin lo = MBRP_SIG_LOW; hi = 8'($urandom); end
        2: begin lo = 8'($urandom); hi = MBRP_SIG_HIGH; end
        default: begin lo = MBRP_SIG_LOW; hi = MBRP_SIG_HIGH; end
      endcase
      build_sector(lo, hi);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 24)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        aligned = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_sector($urandom_range(1, SECTOR_BYTES - 1), 1'b1);
        aligned = 1'b0;
      end
      send_sector(SECTOR_BYTES, !aligned || $urandom_range(0, 1) == 0);
      aligned = 1'b1;
    end
  endtask

  // Back-to-back sectors with no idling on either side
  task automatic test_steady_stream();
    int s;
    int k;
    idle_on = 1'b0;
    for (s = 0; s < 3; s++) begin
      for (k = 0; k < 4; k++) plan[k] = random_entry();
      build_sector(MBRP_SIG_LOW, (s == 1) ? 8'h00 : MBRP_SIG_HIGH);
      send_sector(SECTOR_BYTES, s == 0);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_extreme_entries();
    test_bad_signatures();
    test_sector_wrap();
    test_restart_mid_sector();
    test_random_sectors();
    test_steady_stream();
    byte_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (NUM_ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> mbr_partition_table_parser.f
hw/rtl/mbrp_pkg.sv
hw/rtl/mbrp_datapath.sv
hw/rtl/mbrp_ctrl.sv
hw/rtl/mbr_partition_table_parser.sv
hw/rtl/mbrp_checker.sv
test/mbr_partition_table_parser_test.sv
